/* rtl/core/gclw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclw_pkg
// Shared types and constants for the graph-cut link weight block.
// ----------------------------------------------------------------------------
package gclw_pkg;

    localparam int MaxSeeds  = 64;
    localparam int SeedAw    = $clog2(MaxSeeds);
    localparam int CountW    = $clog2(MaxSeeds + 1);
    localparam int SeedW     = 25;
    localparam int InDataW   = 80;
    localparam int OutDataW  = 48;
    localparam int DivW      = 16;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_PROCESS = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DIV_FGP,
        ST_DIV_BGP,
        ST_DIV_RCOST,
        ST_DIV_DCOST,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        DSEL_FGP,
        DSEL_BGP,
        DSEL_RCOST,
        DSEL_DCOST,
        DSEL_NONE
    } dsel_t;

    typedef struct packed {
        logic  capture;
        logic  seed_write;
        logic  seed_clear;
        logic  scan_start;
        logic  scan_step;
        logic  div_start;
        dsel_t div_sel;
        logic  out_load;
    } gclw_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic out_busy;
    } gclw_stat_t;

    function automatic logic [8:0] hsv_diff(input logic [7:0] h1, input logic [7:0] s1,
                                            input logic [7:0] v1, input logic [7:0] h2,
                                            input logic [7:0] s2, input logic [7:0] v2);
        logic [7:0] dh;
        logic [7:0] ds;
        logic [7:0] dv;
        dh = (h1 > h2) ? h1 - h2 : h2 - h1;
        ds = (s1 > s2) ? s1 - s2 : s2 - s1;
        dv = (v1 > v2) ? v1 - v2 : v2 - v1;
        return {1'b0, dh} + {3'b0, ds[7:2]} + {3'b0, dv[7:2]};
    endfunction

endpackage

/* rtl/core/graph_cut_link_weights.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_cut_link_weights
// Graph-cut prior, terminal and neighbour link weights for HSV pixels.
// ----------------------------------------------------------------------------
// A seed add, clear or unused-command transfer is taken while idle and leaves
// the block idle. A process-pixel transfer walks the filled part of the seed
// table at one entry a cycle through the RAM read port, then runs four
// divisions one after another on a shared 16-step divider and then scales
// the terminal and neighbour links. The next transfer is taken in the cycle
// after the result register is loaded; a result still waiting in that
// register holds the block in its final step. Input is held off while a
// pixel is in progress. Command 3 is consumed and ignored. lambda may only
// be written while the block is idle.
module graph_cut_link_weights (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], hue, saturation, brightness, right_hue, right_saturation,
    // right_brightness, down_hue, down_saturation, down_brightness, mask[1:0]
    input  logic [79:0] s_axis_tdata,
    // seed_foreground
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fg_prior, bg_prior, source_link, sink_link, right_link, down_link
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    import gclw_pkg::*;

    gclw_cmd_t  cmd;
    gclw_stat_t stat;
    cmd_t       in_cmd;

    assign in_cmd = cmd_t'(s_axis_tdata[1:0]);

    gclw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (in_cmd),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gclw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   ({8'd0, s_axis_tdata[73:2]}),
        .in_fg     (s_axis_tuser),
        .in_mask   (s_axis_tdata[75:74]),
        .lambda    (cfg_wdata),
        .lambda_we (cfg_we),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/core/gclw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclw_ram
// Single-port-write, registered-read generic RAM.
// ----------------------------------------------------------------------------
module gclw_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/gclw_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gclw_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gclw_pkg::DivW-1:0] dividend,
    input  logic [gclw_pkg::DivW-1:0] divisor,
    output logic                      done,
    output logic [gclw_pkg::DivW-1:0] quotient
);
    import gclw_pkg::*;

    localparam int CntW = $clog2(DivW + 1);

    logic [DivW-1:0] quo_reg, quo_next;
    logic [DivW-1:0] rem_reg, rem_next;
    logic [DivW-1:0] dsr_reg, dsr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DivW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DivW-1]} - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CntW'(DivW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DivW])
            begin
                rem_next = {rem_reg[DivW-2:0], quo_reg[DivW-1]};
                quo_next = {quo_reg[DivW-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DivW-1:0];
                quo_next = {quo_reg[DivW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/gclw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclw_ctrl
// Sequencer: seed table updates, table scan, the division chain and the output load.
// ----------------------------------------------------------------------------
module gclw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  gclw_pkg::cmd_t        in_cmd,
    output logic                  in_ready,
    input  gclw_pkg::gclw_stat_t  stat,
    output gclw_pkg::gclw_cmd_t   cmd
);
    import gclw_pkg::*;

    state_t state_reg, state_next;
    logic   acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && in_cmd == CMD_PROCESS)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:      if (stat.scan_done) state_next = ST_SCAN_LAST;
            ST_SCAN_LAST: state_next = ST_DIV_FGP;
            ST_DIV_FGP:   if (stat.div_done) state_next = ST_DIV_BGP;
            ST_DIV_BGP:   if (stat.div_done) state_next = ST_DIV_RCOST;
            ST_DIV_RCOST: if (stat.div_done) state_next = ST_DIV_DCOST;
            ST_DIV_DCOST: if (stat.div_done) state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_OUT;
            ST_OUT:       if (!stat.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = DSEL_NONE;
        cmd.capture    = acc;
        cmd.seed_write = acc && (in_cmd == CMD_ADD);
        cmd.seed_clear = acc && (in_cmd == CMD_CLEAR);
        cmd.scan_start = acc && (in_cmd == CMD_PROCESS);
        case (state_reg)
            ST_SCAN:      cmd.scan_step = 1'b1;
            ST_SCAN_LAST:
            begin
                cmd.scan_step = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_FGP;
            end
            ST_DIV_FGP:   begin cmd.div_start = stat.div_done; cmd.div_sel = DSEL_BGP;   end
            ST_DIV_BGP:   begin cmd.div_start = stat.div_done; cmd.div_sel = DSEL_RCOST; end
            ST_DIV_RCOST: begin cmd.div_start = stat.div_done; cmd.div_sel = DSEL_DCOST; end
            ST_OUT:       cmd.out_load = !stat.out_busy;
            default:      cmd.div_sel = DSEL_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/gclw_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclw_dp
// Datapath: seed table, minimum search, shared divider, link scaling and output register.
// ----------------------------------------------------------------------------
module gclw_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gclw_pkg::InDataW-1:0] in_data,
    input  logic                         in_fg,
    input  logic [1:0]                   in_mask,
    input  logic [6:0]                   lambda,
    input  logic                         lambda_we,
    input  gclw_pkg::gclw_cmd_t          cmd,
    output gclw_pkg::gclw_stat_t         stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gclw_pkg::OutDataW-1:0] out_data
);
    import gclw_pkg::*;

    logic [6:0]        lambda_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic [7:0]        h_reg, s_reg, v_reg, rh_reg, rs_reg, rv_reg, dh_reg, ds_reg, dv_reg;
    logic [1:0]        mask_reg;
    logic [CountW-1:0] idx_reg;
    logic              rd_valid_reg;
    logic [8:0]        df_reg, db_reg;
    logic [SeedW-1:0]  rdata;
    logic [8:0]        d;
    logic [DivW-1:0]   q_fgp_reg, q_bgp_reg, q_rc_reg, q_dc_reg;
    logic [DivW-1:0]   dvd, dsr, quo;
    logic              ddone;
    logic [6:0]        lsat;
    logic [6:0]        keep;
    logic [13:0]       prod_src_reg, prod_snk_reg;
    logic [15:0]       prod_rl_reg, prod_dl_reg;
    logic [26:0]       src_mul, snk_mul;
    logic [31:0]       rl_mul, dl_mul;
    logic              out_valid_reg;
    logic [OutDataW-1:0] out_reg;
    logic [8:0]        rdiff, ddiff;
    dsel_t             cur_sel_reg;

    assign lsat = (lambda_reg > 7'd100) ? 7'd100 : lambda_reg;
    assign keep = 7'd100 - lsat;

    gclw_ram #(.Width(SeedW), .Depth(MaxSeeds)) u_seed_ram (
        .clk   (clk),
        .we    (cmd.seed_write && (count_reg < CountW'(MaxSeeds))),
        .waddr (count_reg[SeedAw-1:0]),
        .wdata ({in_fg, in_data[7:0], in_data[15:8], in_data[23:16]}),
        .raddr (idx_reg[SeedAw-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.seed_clear)
        begin
            count_next = '0;
        end
        else if (cmd.seed_write && (count_reg < CountW'(MaxSeeds)))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign d = hsv_diff(h_reg, s_reg, v_reg, rdata[23:16], rdata[15:8], rdata[7:0]);
    assign rdiff = hsv_diff(h_reg, s_reg, v_reg, rh_reg, rs_reg, rv_reg);
    assign ddiff = hsv_diff(h_reg, s_reg, v_reg, dh_reg, ds_reg, dv_reg);

    assign stat.scan_done = (idx_reg >= count_reg);
    assign stat.div_done  = ddone;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        dvd = '0;
        dsr = 16'd1;
        case (cmd.div_sel)
            DSEL_FGP:
            begin
                dvd = DivW'(db_reg * 7'd100);
                dsr = DivW'(df_reg) + DivW'(db_reg) + 1'b1;
            end
            DSEL_BGP:
            begin
                dvd = DivW'(df_reg * 7'd100);
                dsr = DivW'(df_reg) + DivW'(db_reg) + 1'b1;
            end
            DSEL_RCOST:
            begin
                dvd = DivW'(254);
                dsr = DivW'(rdiff) + 1'b1;
            end
            DSEL_DCOST:
            begin
                dvd = DivW'(254);
                dsr = DivW'(ddiff) + 1'b1;
            end
            default:
            begin
                dvd = '0;
                dsr = DivW'(1);
            end
        endcase
    end

    gclw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dsr),
        .done     (ddone),
        .quotient (quo)
    );

    // divide by 1000 and by 10 through reciprocal multiplication
    assign src_mul = prod_src_reg * 14'd8389;
    assign snk_mul = prod_snk_reg * 14'd8389;
    assign rl_mul  = prod_rl_reg * 16'd52429;
    assign dl_mul  = prod_dl_reg * 16'd52429;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            cur_sel_reg   <= DSEL_NONE;
        end
        else
        begin
            if (lambda_we)
            begin
                lambda_reg <= lambda;
            end
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_valid_reg <= !stat.scan_done;
                if (!stat.scan_done)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.div_start)
            begin
                cur_sel_reg <= cmd.div_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            h_reg    <= in_data[7:0];
            s_reg    <= in_data[15:8];
            v_reg    <= in_data[23:16];
            rh_reg   <= in_data[31:24];
            rs_reg   <= in_data[39:32];
            rv_reg   <= in_data[47:40];
            dh_reg   <= in_data[55:48];
            ds_reg   <= in_data[63:56];
            dv_reg   <= in_data[71:64];
            mask_reg <= in_mask;
            df_reg   <= 9'd255;
            db_reg   <= 9'd255;
        end
        else if (cmd.scan_step && rd_valid_reg)
        begin
            if (rdata[24])
            begin
                if (d < df_reg) df_reg <= d;
            end
            else
            begin
                if (d < db_reg) db_reg <= d;
            end
        end
        if (ddone)
        begin
            case (cur_sel_reg)
                DSEL_FGP:   q_fgp_reg <= quo;
                DSEL_BGP:   q_bgp_reg <= quo;
                DSEL_RCOST: q_rc_reg  <= quo;
                DSEL_DCOST: q_dc_reg  <= quo;
                default:    ;
            endcase
        end
        prod_src_reg <= q_fgp_reg[6:0] * keep;
        prod_snk_reg <= q_bgp_reg[6:0] * keep;
        prod_rl_reg  <= q_rc_reg[7:0] * (8'd100 + {1'b0, lsat});
        prod_dl_reg  <= q_dc_reg[7:0] * (8'd100 + {1'b0, lsat});
        if (cmd.out_load)
        begin
            out_reg <= {mask_reg[1] ? dl_mul[31:19] : 13'd0,
                        mask_reg[0] ? rl_mul[31:19] : 13'd0,
                        snk_mul[26:23], src_mul[26:23],
                        q_bgp_reg[6:0], q_fgp_reg[6:0]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
